[design/mtt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types, widths and helpers for the A times A-transpose unit.
// ----------------------------------------------------------------------------
package mtt_pkg;

	localparam int MAX_SIZE = 8;
	localparam int DATA_W   = 16;
	localparam int SUM_W    = 35;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int IDX_W    = 3;
	localparam int SIZE_W   = 4;
	localparam int CNT_W    = 7;
	localparam int ADDR_W   = $clog2(MAX_SIZE * MAX_SIZE);
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

	// one finished matrix waiting for the back end
	typedef struct packed {
		logic              bank;
		logic [SIZE_W-1:0] size;
	} job_t;

	// store write request from the front end
	typedef struct packed {
		logic              en;
		logic              bank;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} mem_wr_t;

	// control carried along the multiply-accumulate pipeline
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic             final_entry;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} ctrl_t;

	// clamp the register value to the supported range of sizes
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
		logic [SIZE_W-1:0] n;
		n = raw;
		if (n == '0)
			n = SIZE_W'(1);
		if (n > SIZE_W'(MAX_SIZE))
			n = SIZE_W'(MAX_SIZE);
		return n;
	endfunction

endpackage
`default_nettype wire

[design/mtt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_front
// Holds the size register, takes elements, writes them into the current
// store bank and posts a job when the matrix is complete.
// ----------------------------------------------------------------------------
module mtt_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        busy,
	input  wire logic [mtt_pkg::DATA_W-1:0]  element_value,
	input  wire logic                        cfg_valid,
	input  wire logic [mtt_pkg::SIZE_W-1:0]  cfg_data,
	output      logic                        cfg_ready,
	output      mtt_pkg::mem_wr_t            mem_wr,
	output      logic                        push,
	output      mtt_pkg::job_t               push_job
);

	logic [mtt_pkg::SIZE_W-1:0] size_q;
	logic [mtt_pkg::CNT_W-1:0]  load_count_q;
	logic                       bank_q;
	logic [mtt_pkg::SIZE_W-1:0] n;
	logic [mtt_pkg::CNT_W-1:0]  total;
	logic [mtt_pkg::CNT_W-1:0]  count_next;
	logic                       accept;
	logic                       complete;

	assign cfg_ready  = 1'b1;
	assign accept     = start && !busy;
	assign n          = mtt_pkg::eff_size(size_q);
	assign total      = mtt_pkg::CNT_W'(n) * mtt_pkg::CNT_W'(n);
	assign count_next = load_count_q + mtt_pkg::CNT_W'(1);
	assign complete   = accept && (count_next >= total);

	always_comb begin
		mem_wr.en   = accept;
		mem_wr.bank = bank_q;
		mem_wr.addr = load_count_q[mtt_pkg::ADDR_W-1:0];
		mem_wr.data = element_value;
	end

	assign push          = complete;
	assign push_job.bank = bank_q;
	assign push_job.size = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q       <= mtt_pkg::SIZE_RESET;
			load_count_q <= '0;
			bank_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				size_q <= cfg_data;
			if (complete) begin
				// switch banks so the next matrix loads while this one computes
				load_count_q <= '0;
				bank_q       <= !bank_q;
			end else if (accept) begin
				load_count_q <= count_next;
			end
		end
	end

endmodule
`default_nettype wire

[design/mtt_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_queue
// Short job queue between the loading front end and the compute back end.
// ----------------------------------------------------------------------------
module mtt_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire mtt_pkg::job_t               push_job,
	input  wire logic                        pop,
	output      logic                        pop_valid,
	output      mtt_pkg::job_t               pop_job,
	output      logic [mtt_pkg::QCNT_W-1:0]  count
);

	mtt_pkg::job_t              entries_q [mtt_pkg::QDEPTH];
	logic [mtt_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [mtt_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [mtt_pkg::QCNT_W-1:0] count_q;

	assign pop_valid = (count_q != '0);
	assign pop_job   = entries_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + mtt_pkg::QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + mtt_pkg::QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + mtt_pkg::QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - mtt_pkg::QCNT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != mtt_pkg::QCNT_W'(mtt_pkg::QDEPTH)))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("job queue underflow");
`endif

endmodule
`default_nettype wire

[design/mtt_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_back
// Two-bank element store and one shared multiply-accumulate. Walks i, j, k
// for each job and emits one product entry for each (i, j) pair.
// ----------------------------------------------------------------------------
module mtt_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire mtt_pkg::mem_wr_t                   mem_wr,
	input  wire logic                               job_valid,
	input  wire mtt_pkg::job_t                      job,
	output      logic                               pop,
	output      logic                               active,
	output      logic                               result_valid,
	output      logic [mtt_pkg::IDX_W-1:0]          row_index,
	output      logic [mtt_pkg::IDX_W-1:0]          column_index,
	output      logic signed [mtt_pkg::SUM_W-1:0]   product_value,
	output      logic                               last_entry
);

	localparam int MEM_AW = mtt_pkg::ADDR_W + 1;

	logic [mtt_pkg::DATA_W-1:0] mem_q [2 ** MEM_AW];

	logic                       active_q;
	logic                       bank_q;
	logic [mtt_pkg::SIZE_W-1:0] size_q;
	logic [mtt_pkg::IDX_W-1:0]  i_q;
	logic [mtt_pkg::IDX_W-1:0]  j_q;
	logic [mtt_pkg::IDX_W-1:0]  k_q;

	logic [mtt_pkg::ADDR_W-1:0] n_ext;
	logic [mtt_pkg::ADDR_W-1:0] addr_a;
	logic [mtt_pkg::ADDR_W-1:0] addr_b;
	logic [mtt_pkg::IDX_W-1:0]  last_idx;
	logic                       k_end;
	logic                       j_end;
	logic                       i_end;
	mtt_pkg::ctrl_t             ctrl_s0;

	logic signed [mtt_pkg::DATA_W-1:0] a_s1;
	logic signed [mtt_pkg::DATA_W-1:0] b_s1;
	mtt_pkg::ctrl_t                    ctrl_s1;
	logic signed [mtt_pkg::PROD_W-1:0] prod_s2;
	mtt_pkg::ctrl_t                    ctrl_s2;
	logic signed [mtt_pkg::SUM_W-1:0]  acc_q;
	logic signed [mtt_pkg::SUM_W-1:0]  prod_ext;
	logic signed [mtt_pkg::SUM_W-1:0]  acc_next;

	logic                              result_valid_q;
	logic [mtt_pkg::IDX_W-1:0]         row_q;
	logic [mtt_pkg::IDX_W-1:0]         col_q;
	logic signed [mtt_pkg::SUM_W-1:0]  value_q;
	logic                              last_q;

	assign pop    = !active_q && job_valid;
	assign active = active_q;

	// element (r, k) sits at r*n+k of the bank
	assign n_ext    = mtt_pkg::ADDR_W'(size_q);
	assign addr_a   = mtt_pkg::ADDR_W'(i_q) * n_ext + mtt_pkg::ADDR_W'(k_q);
	assign addr_b   = mtt_pkg::ADDR_W'(j_q) * n_ext + mtt_pkg::ADDR_W'(k_q);
	assign last_idx = mtt_pkg::IDX_W'(size_q - mtt_pkg::SIZE_W'(1));
	assign k_end    = (k_q == last_idx);
	assign j_end    = (j_q == last_idx);
	assign i_end    = (i_q == last_idx);

	always_comb begin
		ctrl_s0.valid       = active_q;
		ctrl_s0.first       = (k_q == '0);
		ctrl_s0.last        = k_end;
		ctrl_s0.final_entry = i_end && j_end;
		ctrl_s0.row         = i_q;
		ctrl_s0.col         = j_q;
	end

	always_ff @(posedge clk) begin
		if (mem_wr.en)
			mem_q[{mem_wr.bank, mem_wr.addr}] <= mem_wr.data;
		a_s1 <= mem_q[{bank_q, addr_a}];
		b_s1 <= mem_q[{bank_q, addr_b}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			bank_q   <= 1'b0;
			size_q   <= mtt_pkg::SIZE_RESET;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			bank_q   <= job.bank;
			size_q   <= job.size;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
		end else if (active_q) begin
			if (!k_end) begin
				k_q <= k_q + mtt_pkg::IDX_W'(1);
			end else begin
				k_q <= '0;
				if (!j_end) begin
					j_q <= j_q + mtt_pkg::IDX_W'(1);
				end else begin
					j_q <= '0;
					if (!i_end)
						i_q <= i_q + mtt_pkg::IDX_W'(1);
					else
						active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
	end

	assign prod_ext = mtt_pkg::SUM_W'(prod_s2);
	assign acc_next = ctrl_s2.first ? prod_ext : acc_q + prod_ext;

	always_ff @(posedge clk) begin
		if (ctrl_s2.valid)
			acc_q <= acc_next;
		if (ctrl_s2.valid && ctrl_s2.last) begin
			row_q   <= ctrl_s2.row;
			col_q   <= ctrl_s2.col;
			value_q <= acc_next;
			last_q  <= ctrl_s2.final_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1        <= '0;
			ctrl_s2        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			ctrl_s1        <= ctrl_s0;
			ctrl_s2        <= ctrl_s1;
			result_valid_q <= ctrl_s2.valid && ctrl_s2.last;
		end
	end

	assign result_valid  = result_valid_q;
	assign row_index     = row_q;
	assign column_index  = col_q;
	assign product_value = value_q;
	assign last_entry    = last_q;

`ifndef SYNTHESIS
	a_last_on_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && last_q) |-> (row_q == col_q))
		else $error("last entry off the diagonal");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (mtt_pkg::SIZE_W'(k_q) < size_q))
		else $error("reduction index past matrix size");
`endif

endmodule
`default_nettype wire

[design/matrix_times_own_transpose.sv]
`timescale 1ns / 1ps
`default_nettype none
// With the back end idle, the queue hands the job over once the element closing an n x n
// matrix is accepted; each term then passes the store read, product and output registers.
// Product entries follow one per (i, j) pair; results cannot be stalled by the receiver.
// One shared multiply-accumulate computes every term of each matrix; busy holds input
// while one matrix computes and the next waits.
// Reset clears counters and sets size to 8; store contents stay undefined.
// ----------------------------------------------------------------------------
// matrix_times_own_transpose
// Computes P = A * A^T for a square matrix streamed in row-major order.
// ----------------------------------------------------------------------------
module matrix_times_own_transpose (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output      logic                               busy,
	input  wire logic signed [mtt_pkg::DATA_W-1:0]  element_value,
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [mtt_pkg::SIZE_W-1:0]         cfg_data,
	output      logic                               result_valid,
	output      logic [mtt_pkg::IDX_W-1:0]          row_index,
	output      logic [mtt_pkg::IDX_W-1:0]          column_index,
	output      logic signed [mtt_pkg::SUM_W-1:0]   product_value,
	output      logic                               last_entry
);

	mtt_pkg::mem_wr_t           mem_wr;
	logic                       push;
	mtt_pkg::job_t              push_job;
	logic                       pop;
	logic                       job_valid;
	mtt_pkg::job_t              job;
	logic [mtt_pkg::QCNT_W-1:0] q_count;
	logic                       active;

	// both banks in use: one job running or queued plus one more queued
	assign busy = ((mtt_pkg::QCNT_W + 1)'(q_count) + (mtt_pkg::QCNT_W + 1)'(active))
		>= (mtt_pkg::QCNT_W + 1)'(2);

	mtt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.element_value (element_value),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.cfg_ready     (cfg_ready),
		.mem_wr        (mem_wr),
		.push          (push),
		.push_job      (push_job)
	);

	mtt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.pop_valid (job_valid),
		.pop_job   (job),
		.count     (q_count)
	);

	mtt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mem_wr        (mem_wr),
		.job_valid     (job_valid),
		.job           (job),
		.pop           (pop),
		.active        (active),
		.result_valid  (result_valid),
		.row_index     (row_index),
		.column_index  (column_index),
		.product_value (product_value),
		.last_entry    (last_entry)
	);

endmodule
`default_nettype wire

[test/tb_matrix_times_own_transpose.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_times_own_transpose
// Streams square matrices into the A times A-transpose unit and checks every
// product entry (row, column, sum, last flag) against a behavioral model kept
// in the bench. Covers the reset size, clamped sizes, size changes in the
// middle of a load, extreme operands and randomized traffic with idle bursts.
// ----------------------------------------------------------------------------
module tb_matrix_times_own_transpose;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int SETTLE_TICKS = 16;
	localparam int RANDOM_ITEMS = 230;

	typedef struct {
		logic [mtt_pkg::IDX_W-1:0]        row;
		logic [mtt_pkg::IDX_W-1:0]        col;
		logic signed [mtt_pkg::SUM_W-1:0] value;
		logic                             last;
	} gram_entry_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              start = 1'b0;
	logic                              busy;
	logic signed [mtt_pkg::DATA_W-1:0] element_value = '0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [mtt_pkg::SIZE_W-1:0]        cfg_data = '0;
	logic                              result_valid;
	logic [mtt_pkg::IDX_W-1:0]         row_index;
	logic [mtt_pkg::IDX_W-1:0]         column_index;
	logic signed [mtt_pkg::SUM_W-1:0]  product_value;
	logic                              last_entry;

	// bench copy of the block state
	logic [mtt_pkg::SIZE_W-1:0]        size_reg = mtt_pkg::SIZE_RESET;
	logic signed [mtt_pkg::DATA_W-1:0] a_copy [mtt_pkg::MAX_SIZE*mtt_pkg::MAX_SIZE];
	logic [mtt_pkg::CNT_W-1:0]         load_tally = '0;
	gram_entry_t                       gram_entries_due[$];
	gram_entry_t                       want;

	bit idle_bursts = 1'b1;
	int fail_count = 0;
	int cycle_count = 0;
	int elements_sent = 0;
	int matrices_done = 0;
	int results_checked = 0;
	int midload_changes = 0;
	logic [15:0] sizes_written = '0;

	matrix_times_own_transpose dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.element_value(element_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.row_index    (row_index),
		.column_index (column_index),
		.product_value(product_value),
		.last_entry   (last_entry)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int size_in_force();
		if (size_reg == '0)
			return 1;
		if (size_reg > mtt_pkg::MAX_SIZE)
			return mtt_pkg::MAX_SIZE;
		return int'(size_reg);
	endfunction

	// store one element; on the closing element queue the whole product matrix
	function automatic void load_and_multiply(input logic signed [mtt_pkg::DATA_W-1:0] v);
		int n;
		longint acc;
		gram_entry_t e;
		n = size_in_force();
		if (load_tally < mtt_pkg::MAX_SIZE * mtt_pkg::MAX_SIZE)
			a_copy[load_tally[mtt_pkg::ADDR_W-1:0]] = v;
		load_tally = load_tally + mtt_pkg::CNT_W'(1);
		if (int'(load_tally) < n * n)
			return;
		load_tally = '0;
		matrices_done++;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				acc = 0;
				for (int k = 0; k < n; k++)
					acc += longint'(a_copy[i*n+k]) * longint'(a_copy[j*n+k]);
				e.row   = mtt_pkg::IDX_W'(i);
				e.col   = mtt_pkg::IDX_W'(j);
				e.value = acc[mtt_pkg::SUM_W-1:0];
				e.last  = (i == n - 1) && (j == n - 1);
				gram_entries_due.push_back(e);
			end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (gram_entries_due.size() == 0) begin
				$error("product entry (%0d,%0d) arrived with nothing pending",
					row_index, column_index);
				fail_count++;
			end else begin
				want = gram_entries_due.pop_front();
				results_checked++;
				if (row_index !== want.row) begin
					$error("row_index: expected %0d, got %0d", want.row, row_index);
					fail_count++;
				end
				if (column_index !== want.col) begin
					$error("column_index: expected %0d, got %0d", want.col, column_index);
					fail_count++;
				end
				if (product_value !== want.value) begin
					$error("product_value: expected %0d, got %0d", want.value, product_value);
					fail_count++;
				end
				if (last_entry !== want.last) begin
					$error("last_entry: expected %0b, got %0b", want.last, last_entry);
					fail_count++;
				end
			end
		end
	end

	task automatic send_element(input logic signed [mtt_pkg::DATA_W-1:0] v);
		start <= 1'b1;
		element_value <= v;
		do @(posedge clk); while (busy);
		load_and_multiply(v);
		elements_sent++;
		if (idle_bursts && $urandom_range(0, 3) == 0) begin
			// drop the request and scramble the data bus while idle
			start <= 1'b0;
			element_value <= mtt_pkg::DATA_W'($urandom);
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic wait_for_products();
		int waited;
		waited = 0;
		start <= 1'b0;
		@(posedge clk);
		while (gram_entries_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (gram_entries_due.size() != 0) begin
			$error("%0d product entries never arrived", gram_entries_due.size());
			fail_count++;
			gram_entries_due.delete();
		end
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic set_matrix_size(input logic [mtt_pkg::SIZE_W-1:0] sz);
		wait_for_products();
		if (load_tally != '0)
			midload_changes++;
		cfg_valid <= 1'b1;
		cfg_data <= sz;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_reg = sz;
		sizes_written[sz] = 1'b1;
	endtask

	function automatic logic signed [mtt_pkg::DATA_W-1:0] pick_element();
		case ($urandom_range(0, 7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return '0;
			3: return -16'sd1;
			default: return mtt_pkg::DATA_W'($urandom);
		endcase
	endfunction

	task automatic send_random_run(input int count);
		for (int c = 0; c < count; c++)
			send_element(pick_element());
	endtask

	// size 8 straight out of reset, rows chosen to hit both ends of the sum range
	task automatic test_reset_size_extremes();
		logic signed [mtt_pkg::DATA_W-1:0] v;
		for (int r = 0; r < mtt_pkg::MAX_SIZE; r++) begin
			for (int k = 0; k < mtt_pkg::MAX_SIZE; k++) begin
				case (r)
					0: v = -16'sd32768;
					1: v = 16'sd32767;
					2: v = '0;
					3: v = -16'sd1;
					4: v = (k % 2 == 0) ? -16'sd32768 : 16'sd32767;
					5: v = 16'sh5555;
					6: v = 16'shAAAA;
					default: v = mtt_pkg::DATA_W'(1 << (2 * k + 1));
				endcase
				send_element(v);
			end
		end
	endtask

	task automatic test_single_element_sizes();
		set_matrix_size(mtt_pkg::SIZE_W'(1));
		send_element(16'sd32767);
		send_element(-16'sd32768);
		send_element(-16'sd1);
		// zero behaves as a 1 x 1 matrix
		set_matrix_size('0);
		send_element('0);
		send_element(16'sd1);
	endtask

	task automatic test_size_change_midload();
		set_matrix_size(mtt_pkg::SIZE_W'(3));
		send_random_run(5);
		// shrink past the tally: next element closes the matrix
		set_matrix_size(mtt_pkg::SIZE_W'(2));
		send_random_run(1);
		send_random_run(2);
		// grow: keep loading up to the new total
		set_matrix_size(mtt_pkg::SIZE_W'(3));
		send_random_run(7);
		set_matrix_size(mtt_pkg::SIZE_W'(7));
		send_random_run(3);
		set_matrix_size(mtt_pkg::SIZE_W'(1));
		send_random_run(1);
	endtask

	task automatic test_random_matrices();
		logic [mtt_pkg::SIZE_W-1:0] plan [7];
		logic [mtt_pkg::SIZE_W-1:0] sz;
		int n;
		int phase;
		int sent_here;
		int runs;
		plan = '{mtt_pkg::SIZE_W'(2), mtt_pkg::SIZE_W'(8), mtt_pkg::SIZE_W'(15),
			mtt_pkg::SIZE_W'(1), mtt_pkg::SIZE_W'(0), mtt_pkg::SIZE_W'(11),
			mtt_pkg::SIZE_W'(5)};
		phase = 0;
		sent_here = 0;
		while (sent_here < RANDOM_ITEMS) begin
			if (phase < 7)
				sz = plan[phase];
			else if ($urandom_range(0, 3) == 0)
				sz = mtt_pkg::SIZE_W'($urandom_range(0, 15));
			else
				sz = mtt_pkg::SIZE_W'($urandom_range(1, 4));
			phase++;
			set_matrix_size(sz);
			n = size_in_force();
			runs = (n >= 6) ? 1 : $urandom_range(1, 3);
			send_random_run(runs * n * n);
			sent_here += runs * n * n;
			// leave a partial load behind now and then
			if (n > 1 && $urandom_range(0, 3) == 0) begin
				runs = $urandom_range(1, n * n - 1);
				send_random_run(runs);
				sent_here += runs;
			end
		end
	endtask

	task automatic test_back_to_back();
		idle_bursts = 1'b0;
		set_matrix_size(mtt_pkg::SIZE_W'(4));
		send_random_run(4 * 16);
		set_matrix_size(mtt_pkg::SIZE_W'(1));
		send_random_run(20);
		set_matrix_size(mtt_pkg::SIZE_W'(3));
		send_random_run(2 * 9);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size_extremes();
		test_single_element_sizes();
		test_size_change_midload();
		test_random_matrices();
		test_back_to_back();
		wait_for_products();

		$display("Sent %0d elements, closed %0d matrices, checked %0d product entries.",
			elements_sent, matrices_done, results_checked);
		$display("Size codes written (bit mask) %04h, with %0d changes during a load.",
			sizes_written, midload_changes);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
